// File: hw/rtl/ghb_pkg.sv
// ---------------------------------------------------------------------------
// ghb_pkg
// Shared opcodes, field widths and the stage control struct of the
// gradient histogram builder.
// ---------------------------------------------------------------------------
package ghb_pkg;

    localparam int BIN_WIDTH   = 8;
    localparam int GRAD_WIDTH  = 32;
    localparam int COUNT_WIDTH = 32;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_READ       = 1'b1;

    // control of the item sitting in the update stage
    typedef struct packed {
        logic                 valid;
        logic                 opcode;
        logic                 in_range;
        logic [BIN_WIDTH-1:0] bin_index;
    } s1_ctrl_t;

endpackage

// File: hw/rtl/ghb_ifs.sv
// ---------------------------------------------------------------------------
// ghb_ifs
// Valid/ready stream interfaces: sample beats in, bin result beats out.
// ---------------------------------------------------------------------------
interface ghb_sample_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  bin_index;
    logic signed [31:0] gradient;
    logic signed [31:0] hessian;

    modport source (output valid, opcode, bin_index, gradient, hessian, input ready);
    modport sink   (input valid, opcode, bin_index, gradient, hessian, output ready);
endinterface

interface ghb_result_if #(parameter int SUM_WIDTH = 48);
    logic        valid;
    logic        ready;
    logic [7:0]  read_bin;
    logic signed [SUM_WIDTH-1:0] gradient_total;
    logic signed [SUM_WIDTH-1:0] hessian_total;
    logic [31:0] sample_count;

    modport source (output valid, read_bin, gradient_total, hessian_total, sample_count,
                    input ready);
    modport sink   (input valid, read_bin, gradient_total, hessian_total, sample_count,
                    output ready);
endinterface

// File: hw/rtl/ghb_ram.sv
// ---------------------------------------------------------------------------
// ghb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module ghb_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/ghb_update.sv
// ---------------------------------------------------------------------------
// ghb_update
// Read-modify-write arithmetic of one bin: saturating sums, saturating
// count, read-and-clear.
// ---------------------------------------------------------------------------
module ghb_update #(
    parameter int SUM_WIDTH = 48
) (
    input  ghb_pkg::s1_ctrl_t                     ctrl,
    input  logic signed [ghb_pkg::GRAD_WIDTH-1:0] gradient,
    input  logic signed [ghb_pkg::GRAD_WIDTH-1:0] hessian,
    input  logic signed [SUM_WIDTH-1:0]           cur_grad,
    input  logic signed [SUM_WIDTH-1:0]           cur_hess,
    input  logic [ghb_pkg::COUNT_WIDTH-1:0]       cur_count,
    output logic                                  write_en,
    output logic signed [SUM_WIDTH-1:0]           new_grad,
    output logic signed [SUM_WIDTH-1:0]           new_hess,
    output logic [ghb_pkg::COUNT_WIDTH-1:0]       new_count,
    output logic signed [SUM_WIDTH-1:0]           res_grad,
    output logic signed [SUM_WIDTH-1:0]           res_hess,
    output logic [ghb_pkg::COUNT_WIDTH-1:0]       res_count
);

    import ghb_pkg::*;

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // one guard bit holds the exact sum; guard and sign differ on overflow
    function automatic logic [SUM_WIDTH-1:0] sat_add(
        input logic [SUM_WIDTH-1:0]  sum,
        input logic [GRAD_WIDTH-1:0] addend
    );
        logic [SUM_WIDTH:0] wide;
        logic [SUM_WIDTH-1:0] res;
        wide = {sum[SUM_WIDTH-1], sum}
             + {{(SUM_WIDTH+1-GRAD_WIDTH){addend[GRAD_WIDTH-1]}}, addend};
        if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1])
        begin
            res = wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            res = wide[SUM_WIDTH-1:0];
        end
        return res;
    endfunction

    assign write_en = ctrl.valid && ctrl.in_range;

    always_comb
    begin
        unique case (ctrl.opcode)
            OP_ACCUMULATE:
            begin
                new_grad  = sat_add(cur_grad, gradient);
                new_hess  = sat_add(cur_hess, hessian);
                new_count = (cur_count == {COUNT_WIDTH{1'b1}}) ? cur_count
                                                               : cur_count + 1'b1;
            end
            OP_READ:
            begin
                new_grad  = '0;
                new_hess  = '0;
                new_count = '0;
            end
            default:
            begin
                new_grad  = cur_grad;
                new_hess  = cur_hess;
                new_count = cur_count;
            end
        endcase
    end

    // bins beyond the store read as empty
    assign res_grad  = ctrl.in_range ? cur_grad  : '0;
    assign res_hess  = ctrl.in_range ? cur_hess  : '0;
    assign res_count = ctrl.in_range ? cur_count : '0;

endmodule

// File: hw/rtl/ghb_out_queue.sv
// ---------------------------------------------------------------------------
// ghb_out_queue
// Small result FIFO between the update stage and the output channel.
// ---------------------------------------------------------------------------
module ghb_out_queue #(
    parameter int WIDTH = 136,
    parameter int DEPTH = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop_ready,
    output logic                       pop_valid,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    assign pop_valid = (level_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + LVL_W'(push) - LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/gradient_histogram_builder.sv
// ---------------------------------------------------------------------------
// gradient_histogram_builder
// Per-bin gradient/hessian histogram with saturating sums and counts.
// ---------------------------------------------------------------------------
// Usage:
//   sample (sink): one beat per item. opcode accumulate adds gradient and
//     hessian into bin bin_index and bumps its count; opcode read returns the
//     bin and clears it. Accumulates to bins >= NUM_BINS are dropped; reads of
//     them return zeros.
//   result (source): one beat per read item, in item order.
// Throughput: one item per cycle while sample.ready is high. Each bin's
//   gradient sum, hessian sum and count share one RAM word; an item reads it
//   in the cycle it is accepted and writes it back the next cycle, with a
//   one-entry forward register covering back-to-back hits on the same bin.
// Result path: a read's result beat goes through the update stage register
//   and then the result FIFO before it is offered on the result channel.
// Reset: a clearing pass zeroes the RAM, one bin per cycle, over all NUM_BINS
//   bins; sample.ready stays low until it is done.
// Stall: results queue in a three-entry FIFO; in run, sample.ready drops only
//   when that FIFO plus the in-flight read would overflow.
// ---------------------------------------------------------------------------
module gradient_histogram_builder #(
    parameter int NUM_BINS  = 256,
    parameter int SUM_WIDTH = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    ghb_sample_if.sink          sample,
    ghb_result_if.source        result
);

    import ghb_pkg::*;

    localparam int ADDR_W   = $clog2(NUM_BINS);
    localparam int CMP_W    = ((ADDR_W > BIN_WIDTH) ? ADDR_W : BIN_WIDTH) + 1;
    localparam int WORD_W   = 2*SUM_WIDTH + COUNT_WIDTH;
    localparam int RES_W    = BIN_WIDTH + WORD_W;
    localparam int Q_DEPTH  = 3;
    localparam int LVL_W    = $clog2(Q_DEPTH+1);

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    // ---- state and clearing pass ----
    logic              state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // ---- input decode ----
    logic              accept;
    logic [CMP_W-1:0]  bin_ext;
    logic              bin_inside;
    logic [ADDR_W-1:0] rd_addr;

    // ---- update stage ----
    s1_ctrl_t                       s1_ctrl_reg, s1_ctrl_next;
    logic [ADDR_W-1:0]              s1_addr_reg;
    logic signed [GRAD_WIDTH-1:0]   s1_grad_reg;
    logic signed [GRAD_WIDTH-1:0]   s1_hess_reg;
    logic                           s1_read_pending;

    // ---- forward register: last word written by the update stage ----
    logic              fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    // ---- RAM ----
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] new_word;

    logic signed [SUM_WIDTH-1:0] cur_grad, cur_hess;
    logic [COUNT_WIDTH-1:0]      cur_count;
    logic                        upd_we;
    logic signed [SUM_WIDTH-1:0] new_grad, new_hess, res_grad, res_hess;
    logic [COUNT_WIDTH-1:0]      new_count, res_count;

    // ---- result queue ----
    logic              q_push;
    logic [RES_W-1:0]  q_push_data;
    logic [RES_W-1:0]  q_pop_data;
    logic [LVL_W-1:0]  q_level;

    // ---------------------------------------------------------------------
    // clearing pass after reset, then run
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(NUM_BINS-1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                clr_addr_next = clr_addr_reg;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // input side: take a beat when the queue can hold every pending result
    // ---------------------------------------------------------------------
    assign s1_read_pending = s1_ctrl_reg.valid && (s1_ctrl_reg.opcode == OP_READ);
    assign sample.ready    = (state_reg == ST_RUN)
                          && (({1'b0, q_level} + (LVL_W+1)'(s1_read_pending))
                              < (LVL_W+1)'(Q_DEPTH));
    assign accept          = sample.valid && sample.ready;

    assign bin_ext    = CMP_W'(sample.bin_index);
    assign bin_inside = (bin_ext < CMP_W'(NUM_BINS));
    assign rd_addr    = bin_ext[ADDR_W-1:0];

    always_comb
    begin
        s1_ctrl_next.valid     = accept;
        s1_ctrl_next.opcode    = sample.opcode;
        s1_ctrl_next.in_range  = bin_inside;
        s1_ctrl_next.bin_index = sample.bin_index;
    end

    // ---------------------------------------------------------------------
    // update stage: RAM word arrives, forwarded if the previous item hit it
    // ---------------------------------------------------------------------
    assign cur_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_word_reg
                                                                       : ram_rdata;
    assign cur_grad  = cur_word[WORD_W-1 -: SUM_WIDTH];
    assign cur_hess  = cur_word[COUNT_WIDTH +: SUM_WIDTH];
    assign cur_count = cur_word[COUNT_WIDTH-1:0];

    ghb_update #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_update (
        .ctrl      (s1_ctrl_reg),
        .gradient  (s1_grad_reg),
        .hessian   (s1_hess_reg),
        .cur_grad  (cur_grad),
        .cur_hess  (cur_hess),
        .cur_count (cur_count),
        .write_en  (upd_we),
        .new_grad  (new_grad),
        .new_hess  (new_hess),
        .new_count (new_count),
        .res_grad  (res_grad),
        .res_hess  (res_hess),
        .res_count (res_count)
    );

    assign new_word       = {new_grad, new_hess, new_count};
    assign fwd_valid_next = (state_reg == ST_RUN) && upd_we;

    // clearing pass owns the write port until run
    assign ram_we    = (state_reg == ST_CLEAR) || upd_we;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : new_word;

    ghb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------------
    assign q_push      = s1_read_pending;
    assign q_push_data = {s1_ctrl_reg.bin_index, res_grad, res_hess, res_count};

    ghb_out_queue #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop_ready (result.ready),
        .pop_valid (result.valid),
        .pop_data  (q_pop_data),
        .level     (q_level)
    );

    assign result.read_bin       = q_pop_data[RES_W-1 -: BIN_WIDTH];
    assign result.gradient_total = q_pop_data[COUNT_WIDTH+SUM_WIDTH +: SUM_WIDTH];
    assign result.hessian_total  = q_pop_data[COUNT_WIDTH +: SUM_WIDTH];
    assign result.sample_count   = q_pop_data[COUNT_WIDTH-1:0];

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            s1_ctrl_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            s1_ctrl_reg   <= s1_ctrl_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= rd_addr;
            s1_grad_reg <= sample.gradient;
            s1_hess_reg <= sample.hessian;
        end
        if (upd_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_word_reg <= new_word;
        end
    end

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    // queue credit check: a pushed result always finds room
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_level < LVL_W'(Q_DEPTH)))
        else $error("result queue overflow");

    // no beat taken while the clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !sample.ready)
        else $error("sample accepted during clearing pass");

    // a read clears its bin: the forwarded word is zero right after
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_read_pending && s1_ctrl_reg.in_range) |=> (fwd_valid_reg && (fwd_word_reg == '0)))
        else $error("read did not clear bin");

    // bins beyond the store read as empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (CMP_W'(result.read_bin) >= CMP_W'(NUM_BINS)))
        |-> ((result.gradient_total == '0) && (result.hessian_total == '0)
             && (result.sample_count == '0)))
        else $error("out-of-range bin returned nonzero data");

endmodule

// File: tb/tb_gradient_histogram_builder.sv
// ---------------------------------------------------------------------------
// tb_gradient_histogram_builder
// Self-checking bench for the gradient histogram builder: a directed table,
// a back-pressure burst and a random stream, each result beat checked field
// by field against a bin model or, for fixed table rows, a typed-in result.
// ---------------------------------------------------------------------------
module tb_gradient_histogram_builder;

    import ghb_pkg::*;

    localparam int NUM_BINS  = 256;
    localparam int SUM_WIDTH = 48;

    localparam longint SUM_MAX = (64'sd1 <<< (SUM_WIDTH - 1)) - 64'sd1;
    localparam longint SUM_MIN = -(64'sd1 <<< (SUM_WIDTH - 1));

    localparam logic signed [GRAD_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [GRAD_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

    localparam int HOLD_CYCLES  = 60;
    localparam int RANDOM_BEATS = 354;

    // one result beat as the block returns it
    typedef struct packed {
        logic [BIN_WIDTH-1:0]        bin;
        logic signed [SUM_WIDTH-1:0] grad;
        logic signed [SUM_WIDTH-1:0] hess;
        logic [COUNT_WIDTH-1:0]      cnt;
    } bin_result_t;

    // one row of the directed table; fixed rows carry a typed-in result
    typedef struct {
        logic                         op;
        logic [BIN_WIDTH-1:0]         bin;
        logic signed [GRAD_WIDTH-1:0] grad;
        logic signed [GRAD_WIDTH-1:0] hess;
        bit                           fixed;
        bin_result_t                  want;
    } directed_row_t;

    logic clk;
    logic rst_n;

    ghb_sample_if                             sample_bus ();
    ghb_result_if #(.SUM_WIDTH(SUM_WIDTH))    result_bus ();

    gradient_histogram_builder #(
        .NUM_BINS  (NUM_BINS),
        .SUM_WIDTH (SUM_WIDTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus)
    );

    // bin model: sums and counts per bin, cleared at reset and on each read
    logic signed [SUM_WIDTH-1:0] grad_sums  [NUM_BINS];
    logic signed [SUM_WIDTH-1:0] hess_sums  [NUM_BINS];
    logic [COUNT_WIDTH-1:0]      bin_counts [NUM_BINS];

    bin_result_t   pending_reads [$];
    directed_row_t directed_rows [$];

    int  mismatch_count;
    int  beats_accepted;
    int  results_checked;
    int  input_stall_cycles;
    int  gap_max;
    int  burst_left;
    bit  hold_request;

    // -----------------------------------------------------------------------
    // clock and watchdog
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // a run that never finishes is ended and reported as failed
    initial
    begin
        #2_000_000;
        $display("Timeout: %0d result beats still pending", pending_reads.size());
        $display("*** FAILED ***");
        $finish;
    end

    // -----------------------------------------------------------------------
    // bin model
    // -----------------------------------------------------------------------
    function automatic logic signed [SUM_WIDTH-1:0] saturate_sum(
        input logic signed [SUM_WIDTH-1:0]  acc,
        input logic signed [GRAD_WIDTH-1:0] addend
    );
        longint s;
        s = longint'(acc) + longint'(addend);
        if (s > SUM_MAX)
            s = SUM_MAX;
        else if (s < SUM_MIN)
            s = SUM_MIN;
        return s[SUM_WIDTH-1:0];
    endfunction

    // applies one accepted sample beat; returns 1 when it yields a result
    function automatic bit histogram_update(
        input  logic                         op,
        input  logic [BIN_WIDTH-1:0]         bin,
        input  logic signed [GRAD_WIDTH-1:0] grad,
        input  logic signed [GRAD_WIDTH-1:0] hess,
        output bin_result_t                  res
    );
        bit in_store;
        in_store = int'(bin) < NUM_BINS;
        res      = '0;
        if (op == OP_ACCUMULATE)
        begin
            // accumulates to a bin beyond the store are dropped
            if (in_store)
            begin
                grad_sums[bin] = saturate_sum(grad_sums[bin], grad);
                hess_sums[bin] = saturate_sum(hess_sums[bin], hess);
                if (bin_counts[bin] != '1)
                    bin_counts[bin] = bin_counts[bin] + 1'b1;
            end
            return 1'b0;
        end
        // read: return the bin and clear it; gradient and hessian are ignored
        res.bin = bin;
        if (in_store)
        begin
            res.grad        = grad_sums[bin];
            res.hess        = hess_sums[bin];
            res.cnt         = bin_counts[bin];
            grad_sums[bin]  = '0;
            hess_sums[bin]  = '0;
            bin_counts[bin] = '0;
        end
        return 1'b1;
    endfunction

    // -----------------------------------------------------------------------
    // mismatch reporting
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_val);
        mismatch_count++;
        $display("MISMATCH %s: got %h, expected %h (result beat %0d)",
                 what, got, want_val, results_checked);
    endtask

    // -----------------------------------------------------------------------
    // sample source
    // -----------------------------------------------------------------------
    // Offers one beat and returns on the edge where it is taken. Bursts of
    // random length with random gaps; valid stays high across a burst so it
    // is never dropped and raised in the same step. On acceptance the model
    // is updated and, for a read, the expected result is queued (the typed-in
    // one for fixed table rows).
    task automatic send_sample(
        input logic                         op,
        input logic [BIN_WIDTH-1:0]         bin,
        input logic signed [GRAD_WIDTH-1:0] grad,
        input logic signed [GRAD_WIDTH-1:0] hess,
        input bit                           fixed,
        input bin_result_t                  want
    );
        int          gap;
        bin_result_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                sample_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_bus.valid     <= 1'b1;
        sample_bus.opcode    <= op;
        sample_bus.bin_index <= bin;
        sample_bus.gradient  <= grad;
        sample_bus.hessian   <= hess;
        forever
        begin
            @(posedge clk);
            if (sample_bus.ready === 1'b1)
                break;
            if (beats_accepted > 0)
                input_stall_cycles++;
        end
        beats_accepted++;
        if (histogram_update(op, bin, grad, hess, res))
            pending_reads.push_back(fixed ? want : res);
    endtask

    // field values: extremes, zero, unit steps, small values, full random
    function automatic logic signed [GRAD_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return ($urandom_range(0, 1) == 1) ? 32'sd1 : -32'sd1;
            4, 5:    return $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(
        input logic                         op,
        input logic [BIN_WIDTH-1:0]         bin,
        input logic signed [GRAD_WIDTH-1:0] grad,
        input logic signed [GRAD_WIDTH-1:0] hess,
        input bit                           fixed,
        input bin_result_t                  want
    );
        directed_row_t row;
        row.op    = op;
        row.bin   = bin;
        row.grad  = grad;
        row.hess  = hess;
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    initial
    begin : stimulus
        logic [BIN_WIDTH-1:0] hot_bins [6];
        logic [BIN_WIDTH-1:0] bin;
        logic                 op;
        int                   k;

        // every input known from time zero
        rst_n                <= 1'b0;
        sample_bus.valid     <= 1'b0;
        sample_bus.opcode    <= OP_ACCUMULATE;
        sample_bus.bin_index <= '0;
        sample_bus.gradient  <= '0;
        sample_bus.hessian   <= '0;

        mismatch_count     = 0;
        beats_accepted     = 0;
        results_checked    = 0;
        input_stall_cycles = 0;
        gap_max            = 5;
        burst_left         = 0;
        hold_request       = 1'b0;
        foreach (grad_sums[b])
        begin
            grad_sums[b]  = '0;
            hess_sums[b]  = '0;
            bin_counts[b] = '0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; sample_bus.ready stays low through the clearing pass
        add_row(OP_READ,       8'd0,   VAL_MAX, VAL_MIN, 1, '{8'd0,   '0, '0, '0});
        add_row(OP_READ,       8'd255, '0,      '0,      1, '{8'd255, '0, '0, '0});
        add_row(OP_ACCUMULATE, 8'd255, VAL_MAX, VAL_MIN, 0, '0);
        add_row(OP_READ,       8'd255, '0,      '0,      1,
                '{8'd255, 48'sd2147483647, -48'sd2147483648, 32'd1});
        // second read sees the bin cleared by the first
        add_row(OP_READ,       8'd255, VAL_MIN, VAL_MAX, 1, '{8'd255, '0, '0, '0});
        // two hits in a row on one bin; with no gap between them they use the forward register
        add_row(OP_ACCUMULATE, 8'd0,   VAL_MIN, VAL_MAX, 0, '0);
        add_row(OP_ACCUMULATE, 8'd0,   VAL_MIN, VAL_MAX, 0, '0);
        add_row(OP_READ,       8'd0,   '0,      '0,      1,
                '{8'd0, -48'sd4294967296, 48'sd4294967294, 32'd2});
        add_row(OP_ACCUMULATE, 8'd7,   32'sd1,  -32'sd1, 0, '0);
        add_row(OP_ACCUMULATE, 8'd8,   32'sh0001_0000, 32'sh0001_0000, 0, '0);
        add_row(OP_ACCUMULATE, 8'd7,   -32'sd1, 32'sd1,  0, '0);
        add_row(OP_READ,       8'd7,   '0,      '0,      1, '{8'd7, '0, '0, 32'd2});
        add_row(OP_READ,       8'd8,   '0,      '0,      0, '0);
        // zero values still bump the count
        add_row(OP_ACCUMULATE, 8'd9,   '0,      '0,      0, '0);
        add_row(OP_READ,       8'd9,   '0,      '0,      1, '{8'd9, '0, '0, 32'd1});
        // accumulate immediately followed by a read of the same bin
        add_row(OP_ACCUMULATE, 8'd3,   32'sh0001_0000, -32'sh0001_0000, 0, '0);
        add_row(OP_READ,       8'd3,   32'sh5555_5555, 32'shAAAA_AAAA, 0, '0);
        add_row(OP_ACCUMULATE, 8'h55,  32'sh5555_5555, 32'shAAAA_AAAA, 0, '0);
        add_row(OP_ACCUMULATE, 8'hAA,  32'shAAAA_AAAA, 32'sh5555_5555, 0, '0);
        add_row(OP_ACCUMULATE, 8'h55,  32'sh5555_5555, 32'shAAAA_AAAA, 0, '0);
        add_row(OP_READ,       8'h55,  '0,      '0,      0, '0);
        add_row(OP_READ,       8'hAA,  '0,      '0,      0, '0);

        foreach (directed_rows[r])
            send_sample(directed_rows[r].op, directed_rows[r].bin, directed_rows[r].grad,
                        directed_rows[r].hess, directed_rows[r].fixed, directed_rows[r].want);

        // back-pressure: the result side holds off while reads keep coming,
        // so the result FIFO fills and sample_bus.ready must drop
        gap_max      = 0;
        hold_request = 1'b1;
        for (k = 0; k < 24; k++)
            send_sample(OP_READ, 8'($urandom), pick_value(), pick_value(), 0, '0);
        gap_max = 5;

        // random stream: mostly a few hot bins so sums build up and
        // back-to-back hits on a bin are common
        foreach (hot_bins[h])
            hot_bins[h] = 8'($urandom);
        for (k = 0; k < RANDOM_BEATS; k++)
        begin
            if (k == RANDOM_BEATS / 2)
                hold_request = 1'b1;
            if ($urandom_range(0, 9) < 6)
                bin = hot_bins[$urandom_range(0, 5)];
            else
                bin = 8'($urandom);
            op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_ACCUMULATE;
            send_sample(op, bin, pick_value(), pick_value(), 0, '0);
        end
        sample_bus.valid <= 1'b0;

        // drain, then allow the read latency for any stray beat
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Run covered %0d sample beats (directed table, read burst under hold-off,",
                 beats_accepted);
        $display("random stream); %0d result beats checked, input held off %0d cycles, %0d mismatches",
                 results_checked, input_stall_cycles, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // -----------------------------------------------------------------------
    // result sink and checker
    // -----------------------------------------------------------------------
    // ready follows a 16-slot stall pattern, redrawn each time it runs out:
    // sometimes always ready, sometimes mostly ready, sometimes coin flips.
    // A hold request from the source side forces a long hold-off.
    initial
    begin : result_sink
        bin_result_t want;
        logic [15:0] stall_pattern;
        int          slot;
        int          hold_left;

        stall_pattern = '1;
        slot          = 0;
        hold_left     = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (pending_reads.size() == 0)
                    report_mismatch("unexpected result beat, read_bin",
                                    64'(result_bus.read_bin), '0);
                else
                begin
                    want = pending_reads.pop_front();
                    if (result_bus.read_bin !== want.bin)
                        report_mismatch("read_bin", 64'(result_bus.read_bin), 64'(want.bin));
                    if (result_bus.gradient_total !== want.grad)
                        report_mismatch("gradient_total", 64'(result_bus.gradient_total),
                                        64'(want.grad));
                    if (result_bus.hessian_total !== want.hess)
                        report_mismatch("hessian_total", 64'(result_bus.hessian_total),
                                        64'(want.hess));
                    if (result_bus.sample_count !== want.cnt)
                        report_mismatch("sample_count", 64'(result_bus.sample_count),
                                        64'(want.cnt));
                end
                results_checked++;
            end

            if (hold_left == 0 && hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= stall_pattern[slot];
                slot++;
                if (slot == 16)
                begin
                    slot = 0;
                    case ($urandom_range(0, 2))
                        0:       stall_pattern = '1;
                        1:       stall_pattern = 16'($urandom | $urandom);
                        default: stall_pattern = 16'($urandom);
                    endcase
                end
            end
        end
    end

endmodule

// File: gradient_histogram_builder.f
hw/rtl/ghb_pkg.sv
hw/rtl/ghb_ifs.sv
hw/rtl/ghb_ram.sv
hw/rtl/ghb_update.sv
hw/rtl/ghb_out_queue.sv
hw/rtl/gradient_histogram_builder.sv
tb/tb_gradient_histogram_builder.sv
